// ----- rtl/core/trvm_pkg.sv -----
// ----------------------------------------------------------------------------
// trvm_pkg
// Shared types and opcode/status constants for the toy register machine.
// ----------------------------------------------------------------------------
`default_nettype none

package trvm_pkg;

    localparam logic [4:0] OP_MOV  = 5'd0;
    localparam logic [4:0] OP_ADD  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_MUL  = 5'd3;
    localparam logic [4:0] OP_DIV  = 5'd4;
    localparam logic [4:0] OP_INC  = 5'd5;
    localparam logic [4:0] OP_DEC  = 5'd6;
    localparam logic [4:0] OP_JZ   = 5'd7;
    localparam logic [4:0] OP_JNZ  = 5'd8;
    localparam logic [4:0] OP_JMP  = 5'd9;
    localparam logic [4:0] OP_CMP  = 5'd10;
    localparam logic [4:0] OP_NOP  = 5'd11;
    localparam logic [4:0] OP_PUSH = 5'd12;
    localparam logic [4:0] OP_POP  = 5'd13;
    localparam logic [4:0] OP_CALL = 5'd14;
    localparam logic [4:0] OP_RET  = 5'd15;
    localparam logic [4:0] OP_INT  = 5'd16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_DEST  = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;
    localparam logic [2:0] ST_BAD_INT   = 3'd5;

    localparam logic [31:0] HALT_INTERRUPT = 32'd8;

    typedef struct packed {
        logic [4:0]         command;
        logic               first_is_register;
        logic [1:0]         first_register;
        logic signed [31:0] first_immediate;
        logic               second_is_register;
        logic [1:0]         second_register;
        logic signed [31:0] second_immediate;
    } instr_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               zero_flag;
        logic signed [31:0] reg_ax;
        logic signed [31:0] reg_bx;
        logic signed [31:0] reg_cx;
        logic signed [31:0] reg_dx;
        logic [6:0]         stack_count;
        logic [2:0]         status;
        logic               halted;
    } result_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // latch the instruction word
        logic exec;      // decode/execute; starts division or memory read
        logic div_step;  // one quotient bit
        logic commit;    // write back and form the result word
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_div;  // latched instruction is a valid divide
        logic need_pop;  // latched instruction reads the stack
        logic div_last;  // final quotient bit this cycle
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/trvm_ram.sv -----
// ----------------------------------------------------------------------------
// trvm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/trvm_ctrl.sv -----
// ----------------------------------------------------------------------------
// trvm_ctrl
// Sequencer: accept, execute, optional divide or stack read, commit, output.
// ----------------------------------------------------------------------------
`default_nettype none

module trvm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output trvm_pkg::dp_cmd_t       cmd,
    input  wire trvm_pkg::dp_stat_t stat
);
    import trvm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MEM  = 3'd3;
    localparam logic [2:0] S_COMM = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    // A new word may enter while the previous result waits, as long as its
    // commit cannot overwrite that result before it is taken.
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_div)
                begin
                    state_next = S_DIV;
                end
                else if (stat.need_pop)
                begin
                    state_next = S_MEM;
                end
                else
                begin
                    state_next = S_COMM;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_COMM;
                end
            end
            S_MEM:
            begin
                state_next = S_COMM;
            end
            S_COMM:
            begin
                if (!ovalid_next)
                begin
                    cmd.commit  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/trvm_dp.sv -----
// ----------------------------------------------------------------------------
// trvm_dp
// Architectural state, ALU, radix-2 divider and stack for the machine.
// ----------------------------------------------------------------------------
`default_nettype none

module trvm_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int PC_WIDTH    = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire trvm_pkg::instr_t   instr,
    input  wire trvm_pkg::dp_cmd_t  cmd,
    output trvm_pkg::dp_stat_t      stat,
    output trvm_pkg::result_t       result
);
    import trvm_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH + 1);

    // Architectural state.
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic [31:0]         gpr_reg [4];
    logic [31:0]         gpr_next [4];
    logic                zf_reg, zf_next;
    logic [SW-1:0]       sp_reg, sp_next;
    logic                halt_reg, halt_next;

    // Per-item working registers.
    instr_t              ins_reg;
    logic [31:0]         v1_reg, v2_reg;
    logic [2:0]          st_next;
    logic [31:0]         res_reg;     // value for write back
    logic [31:0]         rem_reg, quo_reg, dvs_reg;
    logic [5:0]          dcnt_reg;
    logic                qneg_reg;
    result_t             out_reg;

    // Stack memory.
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [31:0]         mem_wdata, mem_rdata;

    trvm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic        full, empty;
    logic [31:0] a_abs, b_abs;
    logic [32:0] trial;
    logic [31:0] rem_sh;

    assign full  = (sp_reg >= SW'(STACK_DEPTH));
    assign empty = (sp_reg == '0);
    assign a_abs = gpr_reg[0][31] ? (32'd0 - gpr_reg[0]) : gpr_reg[0];
    assign b_abs = v1_reg[31] ? (32'd0 - v1_reg) : v1_reg;

    // One restoring step: shift in next dividend bit from quo_reg.
    assign rem_sh = {rem_reg[30:0], quo_reg[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};

    assign stat.need_div = (ins_reg.command == OP_DIV) && (v1_reg != '0);
    assign stat.need_pop = ((ins_reg.command == OP_POP) || (ins_reg.command == OP_RET))
                           && !empty && !halt_reg;
    assign stat.div_last = (dcnt_reg == 6'd31);

    assign mem_raddr = AW'(sp_reg - SW'(1));
    assign mem_waddr = sp_reg[AW-1:0];
    assign mem_wdata = (ins_reg.command == OP_PUSH) ? v1_reg : 32'(pc_reg);

    // Operand fetch at load.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ins_reg <= instr;
            v1_reg  <= instr.first_is_register ? gpr_reg[instr.first_register]
                                               : instr.first_immediate;
            v2_reg  <= instr.second_is_register ? gpr_reg[instr.second_register]
                                                : instr.second_immediate;
        end
        if (cmd.exec)
        begin
            // Multiply runs here; one 32x32 product, registered.
            res_reg  <= gpr_reg[0] * v1_reg;
            rem_reg  <= '0;
            quo_reg  <= a_abs;
            dvs_reg  <= b_abs;
            dcnt_reg <= '0;
            qneg_reg <= gpr_reg[0][31] ^ v1_reg[31];
        end
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.commit)
        begin
            out_reg <= result_next();
        end
    end

    assign mem_we = cmd.exec && !halt_reg && !full &&
                    ((ins_reg.command == OP_PUSH) || (ins_reg.command == OP_CALL));

    // Next-state computation for commit.
    always_comb
    begin
        logic [31:0]         wv;
        logic [PC_WIDTH-1:0] npc;
        logic [PC_WIDTH-1:0] tgt;
        wv        = '0;
        tgt       = ins_reg.first_immediate[PC_WIDTH-1:0];
        npc       = pc_reg + PC_WIDTH'(1);
        st_next   = ST_OK;
        pc_next   = pc_reg;
        zf_next   = zf_reg;
        sp_next   = sp_reg;
        halt_next = halt_reg;
        for (int i = 0; i < 4; i++)
        begin
            gpr_next[i] = gpr_reg[i];
        end
        if (!halt_reg)
        begin
            case (ins_reg.command)
                OP_MOV:
                begin
                    if (!ins_reg.first_is_register) st_next = ST_BAD_DEST;
                    else gpr_next[ins_reg.first_register] = v2_reg;
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    if (ins_reg.command == OP_ADD) wv = gpr_reg[0] + v1_reg;
                    else if (ins_reg.command == OP_SUB) wv = gpr_reg[0] - v1_reg;
                    else wv = res_reg;
                    gpr_next[0] = wv;
                    zf_next     = (wv == '0);
                end
                OP_DIV:
                begin
                    if (v1_reg == '0) st_next = ST_DIV_ZERO;
                    else
                    begin
                        wv          = qneg_reg ? (32'd0 - quo_reg) : quo_reg;
                        gpr_next[0] = wv;
                        zf_next     = (wv == '0);
                    end
                end
                OP_INC, OP_DEC:
                begin
                    if (!ins_reg.first_is_register) st_next = ST_BAD_DEST;
                    else
                    begin
                        wv = gpr_reg[ins_reg.first_register] +
                             ((ins_reg.command == OP_INC) ? 32'd1 : 32'hFFFF_FFFF);
                        gpr_next[ins_reg.first_register] = wv;
                        zf_next = (wv == '0);
                    end
                end
                OP_JZ:  if (zf_reg) npc = tgt;
                OP_JNZ: if (!zf_reg) npc = tgt;
                OP_JMP: npc = tgt;
                OP_CMP: zf_next = (v1_reg == v2_reg);
                OP_PUSH, OP_CALL:
                begin
                    if (full) st_next = ST_OVERFLOW;
                    else
                    begin
                        sp_next = sp_reg + SW'(1);
                        if (ins_reg.command == OP_CALL) npc = tgt;
                    end
                end
                OP_POP, OP_RET:
                begin
                    if (empty) st_next = ST_UNDERFLOW;
                    else
                    begin
                        sp_next = sp_reg - SW'(1);
                        if (ins_reg.command == OP_RET)
                            npc = mem_rdata[PC_WIDTH-1:0] + PC_WIDTH'(1);
                        else if (ins_reg.first_is_register)
                            gpr_next[ins_reg.first_register] = mem_rdata;
                    end
                end
                OP_INT:
                begin
                    if (ins_reg.first_immediate == HALT_INTERRUPT) halt_next = 1'b1;
                    else st_next = ST_BAD_INT;
                end
                default: ;
            endcase
            if (st_next == ST_OK) pc_next = npc;
            else
            begin
                for (int i = 0; i < 4; i++) gpr_next[i] = gpr_reg[i];
                zf_next   = zf_reg;
                sp_next   = sp_reg;
            end
        end
    end

    function automatic result_t result_next();
        result_t r;
        r.next_pc     = 16'(pc_next);
        r.zero_flag   = zf_next;
        r.reg_ax      = gpr_next[0];
        r.reg_bx      = gpr_next[1];
        r.reg_cx      = gpr_next[2];
        r.reg_dx      = gpr_next[3];
        r.stack_count = 7'(sp_next);
        r.status      = st_next;
        r.halted      = halt_next;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            zf_reg   <= 1'b0;
            sp_reg   <= '0;
            halt_reg <= 1'b0;
            for (int i = 0; i < 4; i++) gpr_reg[i] <= '0;
        end
        else if (cmd.commit)
        begin
            pc_reg   <= pc_next;
            zf_reg   <= zf_next;
            sp_reg   <= sp_next;
            halt_reg <= halt_next;
            for (int i = 0; i < 4; i++) gpr_reg[i] <= gpr_next[i];
        end
    end

    assign result = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/toy_register_vm_execute.sv -----
// ----------------------------------------------------------------------------
// toy_register_vm_execute
// Executes one decoded instruction of a small accumulator machine per word.
// ----------------------------------------------------------------------------
// Each word is loaded, executed and committed; an unhalted pop or ret on a
// non-empty stack adds a registered stack read, and a divide with a nonzero
// divisor adds 32 radix-2 steps. A new word is accepted only after the last
// one has committed. Asynchronous active-low reset clears pc, registers, zero
// flag, stack count and halt; stack contents are undefined until pushed.
`default_nettype none

module toy_register_vm_execute #(
    parameter int STACK_DEPTH = 64,
    parameter int PC_WIDTH    = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire trvm_pkg::instr_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output trvm_pkg::result_t      out_data
);
    import trvm_pkg::*;

    // The controller sequences each word; the datapath holds the machine state.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    trvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    trvm_dp #(.STACK_DEPTH(STACK_DEPTH), .PC_WIDTH(PC_WIDTH)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (in_data),
        .cmd    (cmd),
        .stat   (stat),
        .result (out_data)
    );

    // A commit must never replace a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.commit)
        else $error("result overwritten while stalled");

    // Only one control command is active at a time.
    a_onehot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.div_step, cmd.commit}))
        else $error("conflicting datapath commands");

    // A commit always produces a result word in the next cycle.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit without result");

endmodule

`default_nettype wire

// ----- bench/tb_toy_register_vm_execute.sv -----
// ----------------------------------------------------------------------------
// tb_toy_register_vm_execute
// Self-checking bench for the toy accumulator machine execute stage.
// ----------------------------------------------------------------------------
// Instruction words are driven through the valid/stall input channel. Each
// accepted word is run through a behavioral copy of the machine kept in this
// bench, and the predicted result word is queued. A checker process compares
// every accepted result word, field by field, with the oldest prediction.
// Directed words cover faults, stack limits, divide corner cases and the
// halt interrupt; random programs follow under varying idle patterns and a
// long output hold-off. Stack entries that were never pushed are never read,
// because the predictor only pops what it has pushed since reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_toy_register_vm_execute;
    timeunit 1ns;
    timeprecision 1ps;

    import trvm_pkg::*;

    localparam int DEPTH      = 64;
    localparam int WATCHDOG   = 20000;
    localparam int DRAIN_WAIT = 60;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    instr_t  in_data;
    logic    out_valid;
    logic    out_stall;
    result_t out_data;

    toy_register_vm_execute uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Machine copy used for prediction.
    logic [15:0] mach_pc;
    logic [31:0] mach_reg [4];
    logic        mach_zf;
    logic [31:0] mach_stack [DEPTH];
    int          mach_sp;
    logic        mach_halt;

    result_t expected_q[$];
    int      fail_count;
    int      idle_cycles;

    // Idle percentages; hold_off forces the receiver to stall.
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      hold_off;

    function automatic logic [31:0] quotient_of(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // Execute one word on the machine copy and return the result word.
    function automatic result_t execute_word(instr_t w);
        logic [31:0] v1;
        logic [31:0] v2;
        logic [15:0] npc;
        logic [31:0] top;
        logic [2:0]  st;
        result_t     r;
        st = ST_OK;
        if (!mach_halt) begin
            v1  = w.first_is_register ? mach_reg[w.first_register] : w.first_immediate;
            v2  = w.second_is_register ? mach_reg[w.second_register] : w.second_immediate;
            npc = mach_pc + 16'd1;
            case (w.command)
                OP_MOV:
                begin
                    if (!w.first_is_register) st = ST_BAD_DEST;
                    else mach_reg[w.first_register] = v2;
                end
                OP_ADD:
                begin
                    mach_reg[0] = mach_reg[0] + v1;
                    mach_zf = (mach_reg[0] == 0);
                end
                OP_SUB:
                begin
                    mach_reg[0] = mach_reg[0] - v1;
                    mach_zf = (mach_reg[0] == 0);
                end
                OP_MUL:
                begin
                    mach_reg[0] = mach_reg[0] * v1;
                    mach_zf = (mach_reg[0] == 0);
                end
                OP_DIV:
                begin
                    if (v1 == 0) st = ST_DIV_ZERO;
                    else
                    begin
                        mach_reg[0] = quotient_of(mach_reg[0], v1);
                        mach_zf = (mach_reg[0] == 0);
                    end
                end
                OP_INC, OP_DEC:
                begin
                    if (!w.first_is_register) st = ST_BAD_DEST;
                    else
                    begin
                        mach_reg[w.first_register] = mach_reg[w.first_register] +
                            ((w.command == OP_INC) ? 32'd1 : 32'hFFFF_FFFF);
                        mach_zf = (mach_reg[w.first_register] == 0);
                    end
                end
                OP_JZ:  if (mach_zf) npc = w.first_immediate[15:0];
                OP_JNZ: if (!mach_zf) npc = w.first_immediate[15:0];
                OP_JMP: npc = w.first_immediate[15:0];
                OP_CMP: mach_zf = (v1 == v2);
                OP_PUSH, OP_CALL:
                begin
                    if (mach_sp >= DEPTH) st = ST_OVERFLOW;
                    else
                    begin
                        mach_stack[mach_sp] = (w.command == OP_PUSH) ? v1 : {16'd0, mach_pc};
                        mach_sp++;
                        if (w.command == OP_CALL) npc = w.first_immediate[15:0];
                    end
                end
                OP_POP, OP_RET:
                begin
                    if (mach_sp == 0) st = ST_UNDERFLOW;
                    else
                    begin
                        top = mach_stack[mach_sp - 1];
                        mach_sp--;
                        if (w.command == OP_RET) npc = top[15:0] + 16'd1;
                        else if (w.first_is_register) mach_reg[w.first_register] = top;
                    end
                end
                OP_INT:
                begin
                    if (w.first_immediate == HALT_INTERRUPT) mach_halt = 1'b1;
                    else st = ST_BAD_INT;
                end
                default: ;
            endcase
            if (st == ST_OK) mach_pc = npc;
        end
        r.next_pc     = mach_pc;
        r.zero_flag   = mach_zf;
        r.reg_ax      = mach_reg[0];
        r.reg_bx      = mach_reg[1];
        r.reg_cx      = mach_reg[2];
        r.reg_dx      = mach_reg[3];
        r.stack_count = 7'(mach_sp);
        r.status      = st;
        r.halted      = mach_halt;
        return r;
    endfunction

    function automatic void reset_machine();
        mach_pc   = '0;
        mach_zf   = 1'b0;
        mach_sp   = 0;
        mach_halt = 1'b0;
        for (int i = 0; i < 4; i++) mach_reg[i] = '0;
    endfunction

    // Offer one word and hold it until it is accepted; the prediction is
    // queued at the accepting edge. The task returns at the following
    // falling edge with valid still high, so the next call either offers
    // its word right away or drops valid while it idles.
    task automatic send_word(instr_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_q.insert(expected_q.size(), execute_word(w));
        @(negedge clk);
    endtask

    function automatic instr_t make_word(logic [4:0] cmd, bit r1, logic [1:0] i1,
                                         logic [31:0] imm1, bit r2 = 1'b0,
                                         logic [1:0] i2 = 2'd0, logic [31:0] imm2 = 32'd0);
        instr_t w;
        w.command            = cmd;
        w.first_is_register  = r1;
        w.first_register     = i1;
        w.first_immediate    = imm1;
        w.second_is_register = r2;
        w.second_register    = i2;
        w.second_immediate   = imm2;
        return w;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3: return 32'($urandom_range(20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    // Random word; pushes and pops are equally likely and halts are rare, with
    // fully random noise mixed in.
    function automatic instr_t random_word();
        instr_t w;
        w = make_word(5'($urandom_range(15)), 1'($urandom_range(1)), 2'($urandom_range(3)),
                      random_value(), 1'($urandom_range(1)), 2'($urandom_range(3)),
                      random_value());
        if ($urandom_range(19) == 0) w.command = 5'($urandom_range(31));
        if (w.command == OP_INT)
        begin
            if ($urandom_range(3) != 0) w.first_immediate = 32'($urandom_range(15));
        end
        if ((w.command inside {OP_MOV, OP_INC, OP_DEC}) && $urandom_range(9) != 0)
            w.first_is_register = 1'b1;
        return w;
    endfunction

    // Receiver: stalls at random, or solidly while a hold-off is active.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) out_stall <= 1'b1;
        else out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: %p", out_data);
                fail_count++;
            end
            else
            begin
                result_t e;
                e = expected_q.pop_front();
                if (out_data.next_pc !== e.next_pc)
                begin
                    $error("next_pc expected %0d got %0d", e.next_pc, out_data.next_pc);
                    fail_count++;
                end
                if (out_data.zero_flag !== e.zero_flag)
                begin
                    $error("zero_flag expected %0b got %0b", e.zero_flag, out_data.zero_flag);
                    fail_count++;
                end
                if (out_data.reg_ax !== e.reg_ax)
                begin
                    $error("reg_ax expected %0h got %0h", e.reg_ax, out_data.reg_ax);
                    fail_count++;
                end
                if (out_data.reg_bx !== e.reg_bx)
                begin
                    $error("reg_bx expected %0h got %0h", e.reg_bx, out_data.reg_bx);
                    fail_count++;
                end
                if (out_data.reg_cx !== e.reg_cx)
                begin
                    $error("reg_cx expected %0h got %0h", e.reg_cx, out_data.reg_cx);
                    fail_count++;
                end
                if (out_data.reg_dx !== e.reg_dx)
                begin
                    $error("reg_dx expected %0h got %0h", e.reg_dx, out_data.reg_dx);
                    fail_count++;
                end
                if (out_data.stack_count !== e.stack_count)
                begin
                    $error("stack_count expected %0d got %0d", e.stack_count,
                           out_data.stack_count);
                    fail_count++;
                end
                if (out_data.status !== e.status)
                begin
                    $error("status expected %0d got %0d", e.status, out_data.status);
                    fail_count++;
                end
                if (out_data.halted !== e.halted)
                begin
                    $error("halted expected %0b got %0b", e.halted, out_data.halted);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Faults, arithmetic extremes, jumps, stack underflow and an unsupported interrupt.
    task automatic test_directed();
        send_word(make_word(OP_MOV, 0, 0, 0, 0, 0, 32'd5));         // bad destination
        send_word(make_word(OP_INC, 0, 2, 0));
        send_word(make_word(OP_DEC, 0, 3, 0));
        send_word(make_word(OP_MOV, 1, 0, 0, 0, 0, 32'h8000_0000));
        send_word(make_word(OP_DIV, 0, 0, 32'hFFFF_FFFF));           // wraps
        send_word(make_word(OP_DIV, 0, 0, 32'd0));                   // divide by zero
        send_word(make_word(OP_MOV, 1, 1, 0, 0, 0, 32'hFFFF_FFF9));
        send_word(make_word(OP_MOV, 1, 0, 0, 0, 0, 32'd7));
        send_word(make_word(OP_DIV, 1, 1, 0));                       // exact negative quotient
        send_word(make_word(OP_ADD, 0, 0, 32'd1));
        send_word(make_word(OP_MUL, 1, 1, 0));
        send_word(make_word(OP_SUB, 1, 0, 0));                       // zero result
        send_word(make_word(OP_JZ, 0, 0, 32'h1234_FFFF));
        send_word(make_word(OP_JNZ, 0, 0, 32'd3));
        send_word(make_word(OP_CMP, 1, 2, 0, 0, 0, 32'd1));
        send_word(make_word(OP_JNZ, 0, 0, 32'd40));
        send_word(make_word(OP_JMP, 0, 0, 32'h7FFF_FFFF));
        send_word(make_word(OP_NOP, 0, 0, 0));
        send_word(make_word(5'd31, 1, 3, 32'hFFFF_FFFF, 1, 3, 32'hFFFF_FFFF));
        send_word(make_word(OP_POP, 1, 1, 0));                       // underflow
        send_word(make_word(OP_RET, 0, 0, 0));
        send_word(make_word(OP_CALL, 0, 0, 32'd100));
        send_word(make_word(OP_RET, 0, 0, 0));
        send_word(make_word(OP_INT, 0, 0, 32'd21));                  // unsupported
        send_word(make_word(OP_INC, 1, 3, 0));
    endtask

    // Fill the stack to overflow, then drain it past empty.
    task automatic test_stack_limits();
        for (int i = 0; i < DEPTH; i++)
            send_word(make_word(($urandom_range(1) != 0) ? OP_PUSH : OP_CALL,
                                1'($urandom_range(1)), 2'($urandom_range(3)),
                                random_value()));
        send_word(make_word(OP_PUSH, 0, 0, 32'd1));
        send_word(make_word(OP_CALL, 0, 0, 32'd2));
        for (int i = 0; i <= DEPTH; i++)
            send_word(make_word(($urandom_range(1) != 0) ? OP_POP : OP_RET,
                                1'($urandom_range(1)), 2'($urandom_range(3)), 32'd0));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_word(random_word());
    endtask

    // The receiver holds off long enough for the block to back up its input.
    task automatic test_output_hold_off();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(20);
        join
    endtask

    // Halt, then words that must be ignored with the state reported.
    task automatic test_halt();
        send_word(make_word(OP_INT, 0, 0, HALT_INTERRUPT));
        for (int i = 0; i < 6; i++) send_word(random_word());
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        hold_off      = 1'b0;
        fail_count    = 0;
        idle_cycles   = 0;
        send_idle_pct = 7;
        recv_idle_pct = 61;
        reset_machine();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_stack_limits();
        test_random(300);
        send_idle_pct = 61;
        recv_idle_pct = 7;
        test_random(300);
        test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(120);
        test_halt();
        in_valid <= 1'b0;

        wait_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
